// ===== sv/rtoc_pkg.sv =====
package rtoc_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int MAX_TARGETS = 16;
   localparam int MAX_OTHERS  = 16;
   localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
   localparam int TCNT_W = $clog2(MAX_TARGETS + 1);
   localparam int OCNT_W = $clog2(MAX_OTHERS + 1);
   localparam int PTRS   = MAX_TARGETS + MAX_OTHERS;
   localparam int PIDX_W = (PTRS > 1) ? $clog2(PTRS) : 1;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_FREE   = 2'd1,
      ACT_TARGET = 2'd2,
      ACT_OTHER  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TABLE_FULL = 2'd1,
      ST_SET_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_RESOLVE,
      S_PAIR,
      S_PAIR_CHK,
      S_DONE
   } state_type;

   // word circulating through the region cell chain
   typedef struct packed {
      logic        valid;
      logic [63:0] base;
      logic [63:0] length;
   } region_word_type;

   // control from the sequencer to the cell chain
   typedef struct packed {
      logic        shift;
      logic        append;
      logic        drop_head;
   } chain_ctrl_type;

endpackage

// ===== sv/region_table_overlap_checker.sv =====
// Region table overlap checker.
// Input channel req_*: one word per operation (action, address, byte_size,
// last), accepted when req_valid is high and req_stall low. Result channel
// rsp_*: one word per request (status, evaluated, overlap), taken when
// rsp_valid is high and rsp_stall low.
// Regions live in a ring of cells that rotates one place a cycle while
// the sequencer shifts it. Allocation and a pointer without last go
// straight to S_DONE; a free makes one full rotation of the ring.
// Evaluation with T targets and O others (new pointer included): each
// pointer is resolved by one rotation plus a step, then each ordered pair
// (T x (T+O)) is loaded in S_PAIR and compared in S_PAIR_CHK.
// One item is worked at a time; the next word is accepted at the earliest
// in the cycle where the result is taken.
// Reset (synchronous, active high) empties the region table and both
// pointer sets and drops any pending result. No clearing pass is needed.
// A stalled result holds its value and req_stall stays high until it goes.
module region_table_overlap_checker
   import rtoc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_address,
   input  logic [63:0] req_byte_size,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_evaluated,
   output logic        rsp_overlap
);

   state_type        state_ff, state_in;
   logic [RCNT_W-1:0] rcount_ff, rcount_in;
   logic [TCNT_W-1:0] tcount_ff, tcount_in;
   logic [OCNT_W-1:0] ocount_ff, ocount_in;
   logic [RCNT_W-1:0] step_ff, step_in;   // rotation step
   logic [RCNT_W-1:0] kept_ff, kept_in;   // survivors during free
   logic [PIDX_W:0]   pidx_ff, pidx_in;   // pointer being resolved / pair i
   logic [PIDX_W:0]   pj_ff, pj_in;       // pair j
   logic              found_ff, found_in;
   logic              ovl_ff, ovl_in;
   logic [1:0]        act_ff;
   logic [63:0]       addr_ff;
   logic [63:0]       size_ff;
   logic              last_ff;
   status_type        stat_ff, stat_in;

   logic [63:0] ptr_ff [PTRS];
   logic [63:0] rb_ff  [PTRS];
   logic [63:0] rl_ff  [PTRS];
   logic        ptr_we, res_we;
   logic [PIDX_W-1:0] ptr_wa;
   logic [PIDX_W-1:0] pslot;
   logic [63:0] cur_ptr;

   // pair operands registered before the compare
   logic [63:0] a0_ff, al_ff, b0_ff, bl_ff;
   logic        pv_ff, pv_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic        rsp_eval_ff, rsp_ovl_ff, rsp_load;

   chain_ctrl_type  ctrl;
   region_word_type head;
   logic            accept;
   logic [PIDX_W:0] nptr;

   rtoc_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .new_base   (addr_ff),
      .new_length (size_ff),
      .count      (rcount_ff),
      .head       (head)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign nptr      = (PIDX_W+1)'(tcount_ff) + (PIDX_W+1)'(ocount_ff);
   // targets sit from slot 0, others from slot MAX_TARGETS
   assign pslot     = (pidx_ff < (PIDX_W+1)'(tcount_ff)) ? pidx_ff[PIDX_W-1:0] :
                      PIDX_W'(MAX_TARGETS) + PIDX_W'(pidx_ff - (PIDX_W+1)'(tcount_ff));
   assign cur_ptr   = ptr_ff[pslot];

   // sequencer
   always_comb begin
      logic [63:0] hend;
      logic        hit;
      hend = head.base + head.length;
      hit  = (cur_ptr >= head.base) && (cur_ptr < hend);
      state_in  = state_ff;
      rcount_in = rcount_ff;
      tcount_in = tcount_ff;
      ocount_in = ocount_ff;
      step_in   = step_ff;
      kept_in   = kept_ff;
      pidx_in   = pidx_ff;
      pj_in     = pj_ff;
      found_in  = found_ff;
      ovl_in    = ovl_ff;
      stat_in   = stat_ff;
      pv_in     = 1'b0;
      ctrl      = '0;
      ptr_we    = 1'b0;
      ptr_wa    = '0;
      res_we    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               stat_in  = ST_OK;
               step_in  = '0;
               kept_in  = '0;
               pidx_in  = '0;
               pj_in    = '0;
               found_in = 1'b0;
               ovl_in   = 1'b0;
               case (action_type'(req_action))
                  ACT_ALLOC: state_in = S_DONE;
                  ACT_FREE:  state_in = S_FREE;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_FREE: begin
            // live ring shrinks on each drop; done once every word was seen
            if (kept_ff == rcount_ff) begin
               state_in  = S_DONE;
            end else begin
               ctrl.shift     = 1'b1;
               ctrl.drop_head = (head.base == addr_ff);
               if (head.base == addr_ff) rcount_in = rcount_ff - 1'b1;
               else kept_in = kept_ff + 1'b1;
            end
         end
         S_RESOLVE: begin
            if (pidx_ff == nptr) begin
               pidx_in  = '0;
               pj_in    = '0;
               state_in = (tcount_ff == '0) ? S_DONE : S_PAIR;
            end else if (step_ff == rcount_ff) begin
               // no more regions: unknown pointer keeps length zero
               if (!found_ff) res_we = 1'b1;
               step_in  = '0;
               found_in = 1'b0;
               pidx_in  = pidx_ff + 1'b1;
            end else begin
               ctrl.shift = 1'b1;
               step_in    = step_ff + 1'b1;
               if (!found_ff && hit) begin
                  found_in = 1'b1;
                  res_we   = 1'b1;
               end
            end
         end
         S_PAIR: begin
            // operands are loaded in the clocked block
            pv_in    = (pidx_ff != pj_ff);
            state_in = S_PAIR_CHK;
         end
         S_PAIR_CHK: begin
            if (pv_ff && al_ff != '0 && bl_ff != '0 &&
                a0_ff < b0_ff + bl_ff && b0_ff < a0_ff + al_ff)
               ovl_in = 1'b1;
            if (pj_ff + 1'b1 == nptr) begin
               pj_in   = '0;
               pidx_in = pidx_ff + 1'b1;
               state_in = ((pidx_ff + 1'b1) == (PIDX_W+1)'(tcount_ff)) ? S_DONE : S_PAIR;
            end else begin
               pj_in    = pj_ff + 1'b1;
               state_in = S_PAIR;
            end
         end
         S_DONE: begin
            if (act_ff == ACT_ALLOC) begin
               if (rcount_ff == RCNT_W'(MAX_REGIONS)) begin
                  stat_in = ST_TABLE_FULL;
               end else begin
                  ctrl.append = 1'b1;
                  rcount_in   = rcount_ff + 1'b1;
               end
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else if (act_ff == ACT_FREE) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else if (stat_ff == ST_OK && pidx_ff == '0 && !found_ff && !ovl_ff &&
                         step_ff == '0 && pj_ff == '0 && kept_ff == '0) begin
               // first pass through: store the pointer
               kept_in = RCNT_W'(1);
               if (act_ff == ACT_TARGET) begin
                  if (tcount_ff == TCNT_W'(MAX_TARGETS)) stat_in = ST_SET_FULL;
                  else begin
                     ptr_we    = 1'b1;
                     ptr_wa    = PIDX_W'(tcount_ff);
                     tcount_in = tcount_ff + 1'b1;
                  end
               end else begin
                  if (ocount_ff == OCNT_W'(MAX_OTHERS)) stat_in = ST_SET_FULL;
                  else begin
                     ptr_we    = 1'b1;
                     ptr_wa    = PIDX_W'(MAX_TARGETS) + PIDX_W'(ocount_ff);
                     ocount_in = ocount_ff + 1'b1;
                  end
               end
               if (last_ff) begin
                  state_in = S_RESOLVE;
                  pidx_in  = '0;
                  step_in  = '0;
                  found_in = 1'b0;
                  ovl_in   = 1'b0;
               end else begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (kept_ff == '0 && stat_ff != ST_OK && step_ff == '0 &&
                         pidx_ff == '0 && pj_ff == '0 && !found_ff && !ovl_ff) begin
               // unreachable in practice; status set on first pass already
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               rsp_load = 1'b1;
               if (last_ff) begin
                  tcount_in = '0;
                  ocount_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register and result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rcount_ff    <= '0;
         tcount_ff    <= '0;
         ocount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rcount_ff    <= rcount_in;
         tcount_ff    <= tcount_in;
         ocount_ff    <= ocount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      kept_ff  <= kept_in;
      pidx_ff  <= pidx_in;
      pj_ff    <= pj_in;
      found_ff <= found_in;
      ovl_ff   <= ovl_in;
      stat_ff  <= stat_in;
      pv_ff    <= pv_in;
      if (state_ff == S_IDLE && accept) begin
         act_ff   <= req_action;
         addr_ff  <= req_address;
         size_ff  <= req_byte_size;
         last_ff  <= req_last;
      end
      if (ptr_we) ptr_ff[ptr_wa] <= addr_ff;
      if (res_we) begin
         rb_ff[pslot] <= found_ff || !(step_ff != rcount_ff) ? cur_ptr : head.base;
         rl_ff[pslot] <= (step_ff == rcount_ff) ? 64'd0 : head.length;
      end
      if (state_ff == S_PAIR) begin
         a0_ff <= rb_ff[pidx_ff[PIDX_W-1:0]];
         al_ff <= rl_ff[pidx_ff[PIDX_W-1:0]];
         if (pj_ff < (PIDX_W+1)'(tcount_ff)) begin
            b0_ff <= rb_ff[pj_ff[PIDX_W-1:0]];
            bl_ff <= rl_ff[pj_ff[PIDX_W-1:0]];
         end else begin
            b0_ff <= rb_ff[PIDX_W'(MAX_TARGETS) + PIDX_W'(pj_ff - (PIDX_W+1)'(tcount_ff))];
            bl_ff <= rl_ff[PIDX_W'(MAX_TARGETS) + PIDX_W'(pj_ff - (PIDX_W+1)'(tcount_ff))];
         end
      end
      if (rsp_load) begin
         rsp_status_ff <= stat_in;
         rsp_eval_ff   <= (act_ff[1] && last_ff);
         rsp_ovl_ff    <= (act_ff[1] && last_ff) ? ovl_in : 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_evaluated = rsp_eval_ff;
   assign rsp_overlap   = rsp_ovl_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rcount_ff <= RCNT_W'(MAX_REGIONS)) else $error("region count overflow");
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == S_IDLE) else $error("item taken while busy");
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff) else $error("result lost");
   a_sets_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load && last_ff && act_ff[1] |=> tcount_ff == '0 && ocount_ff == '0)
      else $error("sets not cleared");
`endif

endmodule

// ===== sv/rtoc_cell.sv =====
// One cell of the region chain: holds a region and passes it on when told.
module rtoc_cell
   import rtoc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  region_word_type word_in,
   output region_word_type word_out
);

   region_word_type word_ff;

   // valid bit cleared by reset, payload only on load
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (load) begin
         word_ff.valid <= word_in.valid;
      end
      if (load) begin
         word_ff.base   <= word_in.base;
         word_ff.length <= word_in.length;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== sv/rtoc_chain.sv =====
// Ring of region cells. Cell 0 is the head; a rotation moves every word one
// place towards the head and the head word wraps to the tail (or is dropped).
// Insertion order is kept: the tail holds the newest word after an append.
// A dropped head is not written back, so the live ring closes up by one.
module rtoc_chain
   import rtoc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  chain_ctrl_type  ctrl,
   input  logic [63:0]     new_base,
   input  logic [63:0]     new_length,
   input  logic [RCNT_W-1:0] count,
   output region_word_type head
);

   region_word_type cell_q [MAX_REGIONS];
   region_word_type cell_d [MAX_REGIONS];
   logic            load;

   assign load = ctrl.shift | ctrl.append;

   // next word for each cell: rotate towards head, wrap at the live tail
   always_comb begin
      region_word_type wrap;
      wrap = cell_q[0];
      if (ctrl.drop_head) wrap.valid = 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         if (ctrl.append) begin
            cell_d[i] = cell_q[i];
            if (count[RCNT_W-1:0] == RCNT_W'(i)) begin
               cell_d[i].valid  = 1'b1;
               cell_d[i].base   = new_base;
               cell_d[i].length = new_length;
            end
         end else if (RCNT_W'(i + 1) == count && !ctrl.drop_head) begin
            cell_d[i] = wrap;
         end else if (i + 1 < MAX_REGIONS) begin
            cell_d[i] = cell_q[(i + 1) % MAX_REGIONS];
         end else begin
            cell_d[i] = wrap;
         end
      end
   end

   for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
      rtoc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (load),
         .word_in  (cell_d[g]),
         .word_out (cell_q[g])
      );
   end

   assign head = cell_q[0];

endmodule
